FILE: sv/sisc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisc_pkg - shared types and codes for the sorted index set compare core
// Word layouts for both channels, command and result codes, cell controls.
// ----------------------------------------------------------------------------
package sisc_pkg;

  // command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_CLEAR  = 3'd1;
  localparam logic [2:0] CMD_FIND   = 3'd2;
  localparam logic [2:0] CMD_CMP    = 3'd3;
  localparam logic [2:0] CMD_FINISH = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_INSERT  = 3'd0;
  localparam logic [2:0] KIND_CLEAR   = 3'd1;
  localparam logic [2:0] KIND_FIND    = 3'd2;
  localparam logic [2:0] KIND_ABSENT  = 3'd3;
  localparam logic [2:0] KIND_BOTH    = 3'd4;
  localparam logic [2:0] KIND_SUMMARY = 3'd5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] entry_value;
    logic               found;
    logic               full_res;
    logic [5:0]         count;
    logic               included;
    logic               last;
  } rsp_word_t;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic shift;      // insert: open a slot and load the key
    logic tok_clear;  // cursor token back to cell 0
    logic tok_adv;    // cursor token moves one cell right
  } cell_ctl_t;

endpackage

FILE: sv/sisc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisc_cell - one slot of the sorted chain
// Holds one entry and the cursor token bit, compares its entry against the
// key and takes its left neighbor's entry when an insert opens a slot.
// ----------------------------------------------------------------------------
module sisc_cell #(
  parameter int Idx = 0,
  parameter int CW  = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  sisc_pkg::cell_ctl_t ctl,
  input  logic signed [31:0] key,
  input  logic [CW-1:0]      count,
  input  logic signed [31:0] left_value,
  input  logic               left_lt,
  input  logic               left_tok,
  output logic signed [31:0] value,
  output logic               lt,
  output logic               eq,
  output logic               tok
);

  logic occ;

  // slot holds a live entry
  assign occ = CW'(Idx) < count;
  assign lt  = occ && (value < key);
  assign eq  = occ && (value == key);

  // entry: cells at or right of the insert point move right by one
  always_ff @(posedge clk) begin
    if (ctl.shift && !lt) begin
      value <= left_lt ? key : left_value;
    end
  end

  // cursor token
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctl.tok_clear) begin
      tok <= (Idx == 0);
    end else if (ctl.tok_adv) begin
      tok <= left_tok;
    end
  end

endmodule

FILE: sv/sorted_index_set_compare_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_index_set_compare_core - sorted index set with streaming compare
// A chain of CAPACITY cells keeps the set in ascending order; a token walks
// the chain to merge a second sorted set against it.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           word
//  req      in         req_valid/req_stall  sisc_pkg::req_word_t
//  rsp      out        rsp_valid/rsp_stall  sisc_pkg::rsp_word_t
//
// Insert, clear and find are accepted in S_IDLE, then decided in S_DECIDE, in
// which every cell compares against the key in parallel.
// Compare and finish are accepted, then walk in S_WALK with one result word per step (finish emits at
// least one, a compare may emit none); the token moves one cell per absent or both word.
// rst clears state, count, cursor, absent flag, token and rsp_valid.
// A stalled rsp holds the walk; req is stalled whenever a word is in work.
// ----------------------------------------------------------------------------
module sorted_index_set_compare_core #(
  parameter int CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  sisc_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sisc_pkg::rsp_word_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECIDE = 3'b010,
    S_WALK   = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [2:0]          cmd_r;
  logic signed [31:0]  key;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       cursor, cursor_next;
  logic                any_absent, absent_next;
  sisc_pkg::cell_ctl_t ctl;
  sisc_pkg::rsp_word_t word;
  logic                emit;
  logic                out_free;

  logic signed [31:0]  value_a [CAPACITY];
  logic [CAPACITY-1:0] lt_a, eq_a, tok_a, bnd;
  logic [CW-1:0]       bnd_pos, eq_pos, ins_pos;
  logic                dup, nhit, sel_lt, sel_eq;
  logic signed [31:0]  sel_val;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sisc_cell #(.Idx(i), .CW(CW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key        (key),
      .count      (count),
      .left_value ((i == 0) ? 32'sd0 : value_a[(i == 0) ? 0 : i - 1]),
      .left_lt    ((i == 0) ? 1'b1 : lt_a[(i == 0) ? 0 : i - 1]),
      .left_tok   ((i == 0) ? 1'b0 : tok_a[(i == 0) ? 0 : i - 1]),
      .value      (value_a[i]),
      .lt         (lt_a[i]),
      .eq         (eq_a[i]),
      .tok        (tok_a[i])
    );
  end

  // insert point, match point and token-selected entry
  always_comb begin
    bnd_pos = '0;
    eq_pos  = '0;
    sel_val = '0;
    nhit    = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      bnd[i] = ((i == 0) ? 1'b1 : lt_a[(i == 0) ? 0 : i - 1]) & ~lt_a[i];
      if (bnd[i]) bnd_pos = bnd_pos | CW'(i);
      if (eq_a[i]) eq_pos = eq_pos | CW'(i);
      if (tok_a[i]) sel_val = sel_val | value_a[i];
      if (i > 0) nhit = nhit | (tok_a[(i == 0) ? 0 : i - 1] & (lt_a[i] | eq_a[i]));
    end
    ins_pos = (|bnd) ? bnd_pos : count;
    dup     = |eq_a;
    sel_lt  = |(tok_a & lt_a);
    sel_eq  = |(tok_a & eq_a);
  end

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // sequencer
  always_comb begin
    state_next  = state;
    count_next  = count;
    cursor_next = cursor;
    absent_next = any_absent;
    ctl         = '0;
    emit        = 1'b0;
    word        = '0;
    word.count  = 6'(count);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.cmd == sisc_pkg::CMD_CMP || req.cmd == sisc_pkg::CMD_FINISH)
                       ? S_WALK : S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          state_next = S_IDLE;
          word.last  = 1'b1;
          unique case (cmd_r)
            sisc_pkg::CMD_INSERT: begin
              emit          = 1'b1;
              cursor_next   = '0;
              absent_next   = 1'b0;
              ctl.tok_clear = 1'b1;
              word.kind     = sisc_pkg::KIND_INSERT;
              word.position = 6'(ins_pos);
              if (dup) begin
                word.found       = 1'b1;
                word.entry_value = key;
              end else if (count == CW'(CAPACITY)) begin
                word.full_res = 1'b1;
              end else begin
                ctl.shift        = 1'b1;
                count_next       = count + CW'(1);
                word.count       = 6'(count + CW'(1));
                word.entry_value = key;
              end
            end
            sisc_pkg::CMD_CLEAR: begin
              emit          = 1'b1;
              count_next    = '0;
              cursor_next   = '0;
              absent_next   = 1'b0;
              ctl.tok_clear = 1'b1;
              word.kind     = sisc_pkg::KIND_CLEAR;
              word.count    = '0;
            end
            sisc_pkg::CMD_FIND: begin
              emit      = 1'b1;
              word.kind = sisc_pkg::KIND_FIND;
              if (dup) begin
                word.found       = 1'b1;
                word.position    = 6'(eq_pos);
                word.entry_value = key;
              end else begin
                word.position = 6'(count);
              end
            end
            default: begin
              // unknown codes: no result
              emit = 1'b0;
            end
          endcase
        end
      end
      S_WALK: begin
        word.position    = 6'(cursor);
        word.entry_value = sel_val;
        if (cmd_r == sisc_pkg::CMD_CMP) begin
          priority if (sel_lt) begin
            if (out_free) begin
              emit        = 1'b1;
              word.kind   = sisc_pkg::KIND_ABSENT;
              word.last   = !nhit;
              cursor_next = cursor + CW'(1);
              absent_next = 1'b1;
              ctl.tok_adv = 1'b1;
              if (!nhit) state_next = S_IDLE;
            end
          end else if (sel_eq) begin
            if (out_free) begin
              emit        = 1'b1;
              word.kind   = sisc_pkg::KIND_BOTH;
              word.last   = 1'b1;
              cursor_next = cursor + CW'(1);
              ctl.tok_adv = 1'b1;
              state_next  = S_IDLE;
            end
          end else begin
            state_next = S_IDLE;
          end
        end else if (out_free) begin
          emit = 1'b1;
          if (cursor < count) begin
            word.kind   = sisc_pkg::KIND_ABSENT;
            cursor_next = cursor + CW'(1);
            absent_next = 1'b1;
            ctl.tok_adv = 1'b1;
          end else begin
            word.kind        = sisc_pkg::KIND_SUMMARY;
            word.position    = '0;
            word.entry_value = '0;
            word.included    = !any_absent;
            word.last        = 1'b1;
            cursor_next      = '0;
            absent_next      = 1'b0;
            ctl.tok_clear    = 1'b1;
            state_next       = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      cursor     <= '0;
      any_absent <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      cursor     <= cursor_next;
      any_absent <= absent_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request latch and result word register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cmd_r <= req.cmd;
      key   <= req.value;
    end
    if (emit) begin
      rsp <= word;
    end
  end

  // checks
  a_cursor_in_set: assert property (@(posedge clk) disable iff (rst)
    cursor <= count) else $error("compare cursor beyond entry count");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("entry count beyond capacity");

  a_token_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_a)) else $error("more than one cursor token");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == sisc_pkg::KIND_SUMMARY |-> rsp.last)
    else $error("summary word without last");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for sorted_index_set_compare_core
// Builds sorted sets through inserts, streams second sets against them and
// finishes the merge. Finds, clears and unknown commands are mixed in. Every
// response word is checked against a predictor, with random gaps on the request
// channel and random stalls on the response channel.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAP           = 32;
  localparam int ITEM_TARGET   = 500;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PRINT_CAP     = 40;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    sisc_pkg::req_word_t word;
    bit                  drain;  // hold this word until every pending response is back
  } pending_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  sisc_pkg::req_word_t req       = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  sisc_pkg::rsp_word_t rsp;

  sorted_index_set_compare_core #(.CAPACITY(CAP)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: stored set, merge cursor and absent flag
  // --------------------------------------------------------------------------
  logic signed [31:0]  set_vals [CAP];
  int                  set_len      = 0;
  int                  merge_pos    = 0;
  bit                  merge_missed = 1'b0;
  sisc_pkg::rsp_word_t want_q [$];

  function automatic void push_result(logic [2:0] kind, int pos, logic signed [31:0] val,
                                      bit found, bit full, bit incl);
    sisc_pkg::rsp_word_t w;
    w.kind        = kind;
    w.position    = 6'(pos);
    w.entry_value = val;
    w.found       = found;
    w.full_res    = full;
    w.count       = 6'(set_len);
    w.included    = incl;
    w.last        = 1'b0;
    want_q.insert(want_q.size(), w);
  endfunction

  function automatic void predict_word(sisc_pkg::req_word_t w);
    logic signed [31:0] key;
    int                 p;
    int                 i;
    int                 n_before;
    key      = w.value;
    n_before = want_q.size();
    case (w.cmd)
      sisc_pkg::CMD_INSERT: begin
        merge_pos    = 0;
        merge_missed = 1'b0;
        p = 0;
        while (p < set_len && set_vals[p] < key) p++;
        if (p < set_len && set_vals[p] == key) begin
          push_result(sisc_pkg::KIND_INSERT, p, key, 1'b1, 1'b0, 1'b0);
        end else if (set_len >= CAP) begin
          push_result(sisc_pkg::KIND_INSERT, p, '0, 1'b0, 1'b1, 1'b0);
        end else begin
          for (i = set_len; i > p; i--) set_vals[i] = set_vals[i-1];
          set_vals[p] = key;
          set_len++;
          push_result(sisc_pkg::KIND_INSERT, p, key, 1'b0, 1'b0, 1'b0);
        end
      end
      sisc_pkg::CMD_CLEAR: begin
        set_len      = 0;
        merge_pos    = 0;
        merge_missed = 1'b0;
        push_result(sisc_pkg::KIND_CLEAR, 0, '0, 1'b0, 1'b0, 1'b0);
      end
      sisc_pkg::CMD_FIND: begin
        p = set_len;
        for (i = 0; i < set_len; i++) begin
          if (set_vals[i] == key) begin
            p = i;
            break;
          end
        end
        if (p < set_len)
          push_result(sisc_pkg::KIND_FIND, p, set_vals[p], 1'b1, 1'b0, 1'b0);
        else
          push_result(sisc_pkg::KIND_FIND, set_len, '0, 1'b0, 1'b0, 1'b0);
      end
      sisc_pkg::CMD_CMP: begin
        // stored entries below the element are absent from the other set
        while (merge_pos < set_len && set_vals[merge_pos] < key) begin
          push_result(sisc_pkg::KIND_ABSENT, merge_pos, set_vals[merge_pos],
                      1'b0, 1'b0, 1'b0);
          merge_missed = 1'b1;
          merge_pos++;
        end
        if (merge_pos < set_len && set_vals[merge_pos] == key) begin
          push_result(sisc_pkg::KIND_BOTH, merge_pos, set_vals[merge_pos],
                      1'b0, 1'b0, 1'b0);
          merge_pos++;
        end
      end
      sisc_pkg::CMD_FINISH: begin
        while (merge_pos < set_len) begin
          push_result(sisc_pkg::KIND_ABSENT, merge_pos, set_vals[merge_pos],
                      1'b0, 1'b0, 1'b0);
          merge_missed = 1'b1;
          merge_pos++;
        end
        push_result(sisc_pkg::KIND_SUMMARY, 0, '0, 1'b0, 1'b0, !merge_missed);
        merge_pos    = 0;
        merge_missed = 1'b0;
      end
      default: ;
    endcase
    // tag the final word of this command
    if (want_q.size() > n_before) begin
      want_q[want_q.size() - 1].last = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [31:0] rand_value(int mode);
    case (mode)
      0: return 32'(int'($urandom_range(0, 40)) - 20);
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          3:       return -32'sd1;
          4:       return VAL_MIN + 32'sd1;
          default: return VAL_MAX - 32'sd1;
        endcase
      end
      default: return 32'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus plan, with a view of the stored set for building merge streams
  // --------------------------------------------------------------------------
  pending_t           plan_q [$];
  logic signed [31:0] shadow [$];
  int                 planned   = 0;
  bit                 hold_next = 1'b0;

  function automatic void plan(logic [2:0] cmd, logic signed [31:0] v);
    pending_t it;
    bit       dup;
    int       p;
    it.word.cmd   = cmd;
    it.word.value = v;
    it.drain      = hold_next;
    hold_next     = 1'b0;
    plan_q.insert(plan_q.size(), it);
    if (cmd <= sisc_pkg::CMD_FINISH) planned++;
    if (cmd == sisc_pkg::CMD_CLEAR) begin
      shadow.delete();
    end else if (cmd == sisc_pkg::CMD_INSERT && shadow.size() < CAP) begin
      dup = 1'b0;
      p   = 0;
      foreach (shadow[i]) begin
        if (shadow[i] == v) dup = 1'b1;
        if (shadow[i] < v) p = i + 1;
      end
      if (!dup) shadow.insert(p, v);
    end
  endfunction

  // stream a second sorted set against the stored one, with some breakage
  function automatic void plan_compare_pass();
    logic signed [31:0] lo;
    int                 i;
    int                 keep_pct;
    case ($urandom_range(0, 2))
      0:       keep_pct = 100;
      1:       keep_pct = 85;
      default: keep_pct = 50;
    endcase
    for (i = 0; i < shadow.size(); i++) begin
      if ($urandom_range(0, 99) < 20 && shadow[i] != VAL_MIN) begin
        lo = shadow[i] - 32'sd1;
        if (i == 0 || lo != shadow[i-1]) plan(sisc_pkg::CMD_CMP, lo);
      end
      if ($urandom_range(0, 99) < 4) plan(sisc_pkg::CMD_CMP, rand_value(0));
      if ($urandom_range(0, 99) < 3)
        plan(sisc_pkg::CMD_FIND, shadow[$urandom_range(0, shadow.size() - 1)]);
      if ($urandom_range(0, 99) < keep_pct) plan(sisc_pkg::CMD_CMP, shadow[i]);
    end
    if ($urandom_range(0, 3) == 0) plan(sisc_pkg::CMD_CMP, rand_value(1));
    // now and then abandon the merge and let the next insert or clear reset it
    if ($urandom_range(0, 9) != 0) plan(sisc_pkg::CMD_FINISH, rand_value(1));
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  int unsigned words_sent = 0;
  int          gap_left   = 0;
  bit          send_calm  = 1'b0;

  always @(posedge clk) begin
    pending_t it;
    if (rst) begin
      req_valid <= 1'b0;
      gap_left  = 0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_word(req);
        words_sent++;
        gap_left = send_calm ? 0 : idle_len();
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end
      // a stalled word stays on the bus untouched
      if (!(req_valid && req_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (plan_q.size() != 0 && !(plan_q[0].drain && want_q.size() != 0)) begin
          it = plan_q.pop_front();
          req_valid <= 1'b1;
          req       <= it.word;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor and checker
  // --------------------------------------------------------------------------
  int unsigned mismatches    = 0;
  int unsigned words_checked = 0;
  int unsigned sum_incl      = 0;
  int unsigned sum_excl      = 0;
  int unsigned full_drops    = 0;
  int unsigned dup_hits      = 0;
  int unsigned absent_words  = 0;
  int unsigned both_words    = 0;
  int          stall_left    = 0;
  bit          rsp_calm      = 1'b0;

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    sisc_pkg::rsp_word_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (want_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d position %0d",
                                    rsp.kind, rsp.position));
        end else begin
          want = want_q.pop_front();
          words_checked++;
          check_field("kind", rsp.kind, want.kind);
          check_field("position", rsp.position, want.position);
          check_field("entry_value", rsp.entry_value, want.entry_value);
          check_field("found", rsp.found, want.found);
          check_field("full_res", rsp.full_res, want.full_res);
          check_field("count", rsp.count, want.count);
          check_field("included", rsp.included, want.included);
          check_field("last", rsp.last, want.last);
          if (want.kind == sisc_pkg::KIND_SUMMARY && want.included) sum_incl++;
          if (want.kind == sisc_pkg::KIND_SUMMARY && !want.included) sum_excl++;
          if (want.kind == sisc_pkg::KIND_INSERT && want.full_res) full_drops++;
          if (want.kind == sisc_pkg::KIND_INSERT && want.found) dup_hits++;
          if (want.kind == sisc_pkg::KIND_ABSENT) absent_words++;
          if (want.kind == sisc_pkg::KIND_BOTH) both_words++;
        end
      end
      // random backpressure, with calm stretches
      if (stall_left == 0 && !rsp_calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
      if ($urandom_range(0, 299) == 0) rsp_calm = !rsp_calm;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, want_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int r;
    int n;
    int mode;

    // directed: empty set, extremes, merge corner cases
    plan(sisc_pkg::CMD_FIND, '0);            // miss on empty set
    plan(sisc_pkg::CMD_CMP, '0);             // merge on empty set does nothing
    plan(sisc_pkg::CMD_FINISH, '0);          // empty set is included
    plan(sisc_pkg::CMD_INSERT, '0);
    plan(sisc_pkg::CMD_INSERT, VAL_MAX);
    plan(sisc_pkg::CMD_INSERT, VAL_MIN);
    plan(sisc_pkg::CMD_INSERT, -32'sd1);
    plan(sisc_pkg::CMD_INSERT, 32'sd5);      // lands in the middle
    plan(sisc_pkg::CMD_INSERT, 32'sd5);      // duplicate
    plan(sisc_pkg::CMD_FIND, VAL_MIN);
    plan(sisc_pkg::CMD_FIND, 32'sd3);        // miss
    plan(sisc_pkg::CMD_CMP, VAL_MIN);        // in both
    plan(sisc_pkg::CMD_CMP, -32'sd5);        // smaller than cursor entry: nothing
    plan(sisc_pkg::CMD_CMP, 32'sd3);         // two absent
    plan(sisc_pkg::CMD_CMP, 32'sd3);         // repeated element
    plan(sisc_pkg::CMD_CMP, VAL_MAX);        // one absent, then in both
    plan(sisc_pkg::CMD_CMP, VAL_MAX);        // cursor past the set
    plan(sisc_pkg::CMD_FINISH, '0);
    plan(sisc_pkg::CMD_CMP, 32'sd5);
    plan(sisc_pkg::CMD_INSERT, 32'sd1);      // insert mid-merge resets the cursor
    plan(sisc_pkg::CMD_FINISH, '0);          // everything absent
    plan(sisc_pkg::CMD_CLEAR, '0);
    plan(sisc_pkg::CMD_INSERT, 32'sd10);
    plan(sisc_pkg::CMD_CMP, 32'sd10);
    plan(sisc_pkg::CMD_FINISH, '0);          // fully included
    plan(3'd5, $urandom);                    // unknown commands are ignored
    plan(3'd6, $urandom);
    plan(3'd7, $urandom);

    // random: mostly build-then-merge sequences, the rest noise
    hold_next = 1'b1;
    while (planned < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 4) hold_next = 1'b1;
      if (r < 70) begin
        if ($urandom_range(0, 3) != 0) plan(sisc_pkg::CMD_CLEAR, rand_value(1));
        mode = $urandom_range(0, 3);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 38) : $urandom_range(0, 10);
        repeat (n) plan(sisc_pkg::CMD_INSERT, rand_value(mode));
        plan_compare_pass();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if (shadow.size() != 0 && $urandom_range(0, 1) == 0)
            plan(3'($urandom_range(0, 7)), shadow[$urandom_range(0, shadow.size() - 1)]);
          else
            plan(3'($urandom_range(0, 7)), rand_value($urandom_range(0, 3)));
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (plan_q.size() != 0 || req_valid || want_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (want_q.size() != 0) report_mismatch($sformatf("%0d words never arrived", want_q.size()));

    $display("covered %0d commands and %0d checked response words in %0d cycles",
             words_sent, words_checked, cycle_count);
    $display("merge summaries %0d included / %0d not, %0d absent, %0d in both, %0d dup, %0d full",
             sum_incl, sum_excl, absent_words, both_words, dup_hits, full_drops);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
